### sv/dctb_pkg.sv
package dctb_pkg;

    // telegram layout
    localparam int FRAME_LEN = 10;
    localparam int IDX_W     = 4;

    localparam logic [IDX_W-1:0] IDX_START   = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_ADDR    = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_TYPE    = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_SUBTYPE = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_CTRL    = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_SPD_HI  = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_SPD_LO  = IDX_W'(6);
    localparam logic [IDX_W-1:0] IDX_POS_HI  = IDX_W'(7);
    localparam logic [IDX_W-1:0] IDX_POS_LO  = IDX_W'(8);
    localparam logic [IDX_W-1:0] IDX_CHECK   = IDX_W'(FRAME_LEN - 1);

    // fixed telegram bytes
    localparam logic [7:0] START_BYTE   = 8'h02;
    localparam logic [7:0] TYPE_BYTE    = 8'h05;
    localparam logic [7:0] SUBTYPE_BYTE = 8'h1D;
    localparam logic [7:0] CTRL_ENABLED = 8'h06;
    localparam logic [7:0] CTRL_OTHER   = 8'h01;
    localparam logic [7:0] ENABLE_CODE  = 8'h01;

    // position and speed limits
    localparam logic [7:0]  POS_MAX       = 8'd180;
    localparam logic [7:0]  SPEED_IDX_MAX = 8'd6;
    localparam logic [15:0] SPEED_STEP    = 16'd5000;

    // default depth of the command queue
    localparam int QUEUE_DEPTH_DEF = 2;

    // one classified command, ready to be serialized
    typedef struct packed {
        logic [7:0]  addr;
        logic [7:0]  ctrl;
        logic [15:0] speed;
        logic [7:0]  pos;
        logic [7:0]  check;
    } t_cmd;

endpackage

### sv/dctb_front.sv
module dctb_front
    import dctb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_drive_address,
    input  logic [7:0] i_enable_code,
    input  logic [7:0] i_hundreds_digit,
    input  logic [7:0] i_tens_digit,
    input  logic [7:0] i_units_digit,
    input  logic [7:0] i_speed_index,
    output logic       o_valid,
    input  logic       i_stall,
    output t_cmd       o_cmd
);

    logic        r_valid;
    t_cmd        r_cmd;
    t_cmd        n_cmd;
    logic [14:0] pos_sum;
    logic [7:0]  si_clamped;
    logic        load;

    // weighted digit sum, full width (at most 28305)
    assign pos_sum = ({7'd0, i_hundreds_digit} * 15'd100)
                   + ({7'd0, i_tens_digit} * 15'd10)
                   + {7'd0, i_units_digit};

    assign si_clamped = (i_speed_index > SPEED_IDX_MAX) ? SPEED_IDX_MAX : i_speed_index;

    // classify the command and precompute the check byte
    always_comb begin
        n_cmd.addr  = i_drive_address;
        n_cmd.ctrl  = (i_enable_code == ENABLE_CODE) ? CTRL_ENABLED : CTRL_OTHER;
        n_cmd.speed = {8'd0, si_clamped} * SPEED_STEP;
        n_cmd.pos   = (pos_sum > {7'd0, POS_MAX}) ? POS_MAX : pos_sum[7:0];
        n_cmd.check = START_BYTE ^ TYPE_BYTE ^ SUBTYPE_BYTE ^ n_cmd.addr ^ n_cmd.ctrl
                    ^ n_cmd.speed[15:8] ^ n_cmd.speed[7:0]
                    ^ {4'd0, n_cmd.pos[7:4]} ^ {n_cmd.pos[3:0], 4'd0};
    end

    // one pipeline stage toward the queue
    assign o_stall = r_valid && i_stall;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

### sv/dctb_queue.sv
module dctb_queue
    import dctb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_stall = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd = r_mem[r_rd_ptr];

endmodule

### sv/dctb_back.sv
module dctb_back
    import dctb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_byte,
    output logic       o_last_byte
);

    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_last;
    logic [IDX_W-1:0] r_idx;
    logic [7:0]       n_byte;
    logic             advance;

    // output register free to take the next beat
    assign advance = i_valid && (!r_valid || !i_stall);
    assign o_pop   = advance && (r_idx == IDX_CHECK);

    // pick the telegram byte at the current position
    always_comb begin
        unique case (r_idx)
            IDX_START:   n_byte = START_BYTE;
            IDX_ADDR:    n_byte = i_cmd.addr;
            IDX_TYPE:    n_byte = TYPE_BYTE;
            IDX_SUBTYPE: n_byte = SUBTYPE_BYTE;
            IDX_CTRL:    n_byte = i_cmd.ctrl;
            IDX_SPD_HI:  n_byte = i_cmd.speed[15:8];
            IDX_SPD_LO:  n_byte = i_cmd.speed[7:0];
            IDX_POS_HI:  n_byte = {4'd0, i_cmd.pos[7:4]};
            IDX_POS_LO:  n_byte = {i_cmd.pos[3:0], 4'd0};
            IDX_CHECK:   n_byte = i_cmd.check;
            default:     n_byte = i_cmd.check;
        endcase
    end

    // byte counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_idx   <= (r_idx == IDX_CHECK) ? '0 : r_idx + IDX_W'(1);
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte <= n_byte;
            r_last <= (r_idx == IDX_CHECK);
        end
    end

    assign o_valid      = r_valid;
    assign o_frame_byte = r_byte;
    assign o_last_byte  = r_last;

    // counter never runs past the check byte
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_CHECK)
        else $error("byte counter out of range");

    // a check byte on the output means the counter has wrapped
    a_last_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_idx == IDX_START))
        else $error("counter not wrapped after check byte");

    // a non-final byte on the output leaves the counter mid-frame
    a_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> (r_idx != IDX_START))
        else $error("counter wrapped before check byte");

    // a frame is released from the queue only together with its check byte
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_valid && r_last))
        else $error("queue pop without check byte");

endmodule

### sv/drive_command_telegram_builder_core.sv
// Drive command telegram builder.
// Input channel: one beat per drive command (address, enable code, three
// position digits, speed index), handshake i_valid / o_stall.
// Output channel: ten beats per command, one telegram byte each, in
// transmission order; o_last_byte marks the tenth beat, the XOR check byte.
// Handshake o_valid / i_stall.
// A command beat that is taken passes the classify stage, then the queue,
// then the output register, where its first byte appears.
// The byte serializer sends one byte per cycle while the receiver does not
// stall and the queue holds a command; the classify stage and the command
// queue take new commands while earlier telegrams are still being sent.
// Reset (synchronous, active low) empties the pipeline and the queue and
// restarts the byte counter; no telegram is in flight afterwards.
// When the receiver stalls, the current byte holds; the queue then fills and
// o_stall rises once the queue and the classify stage are both occupied.
module drive_command_telegram_builder_core
    import dctb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_drive_address,
    input  logic [7:0] i_enable_code,
    input  logic [7:0] i_hundreds_digit,
    input  logic [7:0] i_tens_digit,
    input  logic [7:0] i_units_digit,
    input  logic [7:0] i_speed_index,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_byte,
    output logic       o_last_byte
);

    logic front_valid;
    logic queue_stall;
    t_cmd front_cmd;
    logic queue_valid;
    logic queue_pop;
    t_cmd queue_cmd;

    // classify commands
    dctb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_drive_address  (i_drive_address),
        .i_enable_code    (i_enable_code),
        .i_hundreds_digit (i_hundreds_digit),
        .i_tens_digit     (i_tens_digit),
        .i_units_digit    (i_units_digit),
        .i_speed_index    (i_speed_index),
        .o_valid          (front_valid),
        .i_stall          (queue_stall),
        .o_cmd            (front_cmd)
    );

    // decouple front and serializer
    dctb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_stall (queue_stall),
        .i_cmd   (front_cmd),
        .o_valid (queue_valid),
        .i_pop   (queue_pop),
        .o_cmd   (queue_cmd)
    );

    // serialize telegram bytes
    dctb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (queue_valid),
        .i_cmd        (queue_cmd),
        .o_pop        (queue_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte)
    );

endmodule
